// File: sv/ptsc_pkg.sv
// ----------------------------------------------------------------------------
// ptsc_pkg
// Shared types and constants for the PWM tilt sensor conditioner: payload
// structs, register indexes, status codes and the controller/datapath link.
// ----------------------------------------------------------------------------
package ptsc_pkg;

  // Time and fixed-point geometry
  localparam int TIME_BITS  = 32;
  localparam int FRAC_BITS  = 16;
  localparam int ANGLE_BITS = 8 + FRAC_BITS;
  localparam int Q_SHIFT    = FRAC_BITS - 8;
  localparam int CFG_BITS   = 16;
  localparam int ALPHA_BITS = 16;

  // Divider geometry: product of gain and high time, quotient with one
  // guard bit above the angle range
  localparam int PROD_W    = ANGLE_BITS + TIME_BITS;
  localparam int QUO_W     = ANGLE_BITS + 1;
  localparam int DIV_CNT_W = $clog2(QUO_W);
  localparam int EPROD_W   = (ALPHA_BITS + 1) + (ANGLE_BITS + 1);

  localparam logic [ANGLE_BITS-1:0] ANGLE_MAX  = '1;
  localparam logic [ANGLE_BITS-1:0] EWMA_RESET = ANGLE_BITS'(88) << FRAC_BITS;

  // Operation codes
  localparam logic OP_PIN  = 1'b0;
  localparam logic OP_POLL = 1'b1;

  // Status codes
  localparam logic [2:0] STATUS_OK      = 3'd0;
  localparam logic [2:0] STATUS_BELOW   = 3'd1;
  localparam logic [2:0] STATUS_ABOVE   = 3'd2;
  localparam logic [2:0] STATUS_ZERO    = 3'd3;
  localparam logic [2:0] STATUS_TIMEOUT = 3'd4;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWER   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 3'd5;

  // Input transaction
  typedef struct packed {
    logic                 op;
    logic                 pin_level;
    logic [TIME_BITS-1:0] tick_count;
    logic [TIME_BITS-1:0] now_ms;
  } in_item_t;

  // Result transaction
  typedef struct packed {
    logic [ANGLE_BITS-1:0] smoothed_angle;
    logic [ANGLE_BITS-1:0] current_angle;
    logic [2:0]            status;
    logic                  fresh_pulse;
  } out_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic pin_sample;
    logic start_poll;
    logic mul;
    logic dchk;
    logic div_step;
    logic ang;
    logic qual;
    logic emul;
    logic eadd;
    logic load_out;
  } ptsc_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic pending;
    logic period_zero;
  } ptsc_sts_t;

endpackage

// File: sv/ptsc_ctrl.sv
// ----------------------------------------------------------------------------
// ptsc_ctrl
// Sequencer: accepts transactions, steps a poll through multiply, divide,
// qualify and smoothing, and owns the result valid flag.
// ----------------------------------------------------------------------------
module ptsc_ctrl import ptsc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_op,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  ptsc_sts_t sts,
  output ptsc_cmd_t cmd
);

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_MUL  = 9'b000000010,
    ST_DCHK = 9'b000000100,
    ST_DIV  = 9'b000001000,
    ST_ANG  = 9'b000010000,
    ST_QUAL = 9'b000100000,
    ST_EMUL = 9'b001000000,
    ST_EADD = 9'b010000000,
    ST_WB   = 9'b100000000
  } state_t;

  state_t               state_r, state_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 accept;
  logic                 slot_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_op == OP_POLL) begin
            cmd.start_poll = 1'b1;
            if (sts.pending && !sts.period_zero) state_nxt = ST_MUL;
            else state_nxt = ST_QUAL;
          end else begin
            cmd.pin_sample = 1'b1;
          end
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_DCHK;
      end
      ST_DCHK: begin
        cmd.dchk  = 1'b1;
        cnt_nxt   = DIV_CNT_W'(QUO_W - 1);
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r - 1'b1;
        if (cnt_r == '0) state_nxt = ST_ANG;
      end
      ST_ANG: begin
        cmd.ang   = 1'b1;
        state_nxt = ST_QUAL;
      end
      ST_QUAL: begin
        cmd.qual  = 1'b1;
        state_nxt = ST_EMUL;
      end
      ST_EMUL: begin
        cmd.emul  = 1'b1;
        state_nxt = ST_EADD;
      end
      ST_EADD: begin
        cmd.eadd  = 1'b1;
        state_nxt = ST_WB;
      end
      ST_WB: begin
        if (slot_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Result valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (cmd.load_out) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Divider always runs the full quotient width
  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DCHK) |=> (state_r == ST_DIV && cnt_r == DIV_CNT_W'(QUO_W - 1)))
    else $error("divider did not start with full count");

  // A finished poll waits while the result slot is occupied
  a_wb_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WB && out_valid_r && !out_ready) |=> (state_r == ST_WB))
    else $error("result overwritten while still pending");

  // Loading the result raises valid and frees the input side
  a_wb_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WB && slot_free) |=> (out_valid_r && state_r == ST_IDLE))
    else $error("result load did not complete");

endmodule

// File: sv/ptsc_dp.sv
// ----------------------------------------------------------------------------
// ptsc_dp
// Datapath: configuration registers, pulse timing capture, gain multiply,
// restoring divider, qualification, EWMA update and result register.
// ----------------------------------------------------------------------------
module ptsc_dp import ptsc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]  cfg_wdata,
  input  in_item_t             in_data,
  input  ptsc_cmd_t            cmd,
  output ptsc_sts_t            sts,
  output out_item_t            out_data
);

  // Configuration
  logic [CFG_BITS-1:0] alpha_r, gain_r, offset_r, lower_r, upper_r, timeout_r;

  // Pulse capture state
  logic                 prev_level_r;
  logic [TIME_BITS-1:0] rise_stamp_r, period_r, high_r;
  logic                 pending_r;
  logic [TIME_BITS-1:0] last_pulse_ms_r;

  // Angle state
  logic [ANGLE_BITS-1:0] held_r, ewma_r;

  // Per-poll working registers
  logic [TIME_BITS-1:0]       now_r;
  logic                       fresh_r, zero_r, sat_r;
  logic [2:0]                 status_r;
  logic [PROD_W-1:0]          prod_r;
  logic [TIME_BITS-1:0]       rem_r;
  logic [QUO_W-1:0]           dvd_r, quo_r;
  logic signed [EPROD_W-1:0]  eprod_r;
  out_item_t                  out_data_r;

  // Scaled config values
  logic [ANGLE_BITS-1:0] gain_q, offset_q, lower_q, upper_q;
  assign gain_q   = ANGLE_BITS'(gain_r) << Q_SHIFT;
  assign offset_q = ANGLE_BITS'(offset_r) << Q_SHIFT;
  assign lower_q  = ANGLE_BITS'(lower_r) << Q_SHIFT;
  assign upper_q  = ANGLE_BITS'(upper_r) << Q_SHIFT;

  assign sts.pending     = pending_r;
  assign sts.period_zero = (period_r == '0);
  assign out_data        = out_data_r;

  // Divider step: shift in next dividend bit, compare, subtract
  logic [TIME_BITS:0]   div_t;
  logic                 div_ge;
  logic [TIME_BITS-1:0] div_rem;
  assign div_t   = {rem_r, dvd_r[QUO_W-1]};
  assign div_ge  = (div_t >= {1'b0, period_r});
  assign div_rem = div_ge ? TIME_BITS'(div_t - {1'b0, period_r}) : div_t[TIME_BITS-1:0];

  // Quotient beyond the guard bit means the angle saturates
  logic [PROD_W-QUO_W-1:0] prod_top;
  logic                    over;
  assign prod_top = prod_r[PROD_W-1:QUO_W];
  assign over     = ({1'b0, prod_top} >= (PROD_W - QUO_W + 1)'(period_r));

  // Offset plus quotient with saturation
  logic [ANGLE_BITS+1:0]  ang_sum;
  logic [ANGLE_BITS-1:0]  ang_val;
  assign ang_sum = (ANGLE_BITS + 2)'(offset_q) + (ANGLE_BITS + 2)'(quo_r);
  assign ang_val = (sat_r || ang_sum > (ANGLE_BITS + 2)'(ANGLE_MAX)) ?
                   ANGLE_MAX : ang_sum[ANGLE_BITS-1:0];

  // Qualification checks, in priority order
  logic [TIME_BITS-1:0] elapsed;
  logic [2:0]           qual_status;
  assign elapsed = now_r - last_pulse_ms_r;
  always_comb begin
    qual_status = STATUS_OK;
    if (zero_r) qual_status = STATUS_ZERO;
    else if (held_r < lower_q) qual_status = STATUS_BELOW;
    else if (held_r > upper_q) qual_status = STATUS_ABOVE;
    else if (elapsed > TIME_BITS'(timeout_r)) qual_status = STATUS_TIMEOUT;
  end

  // EWMA: ewma + round(alpha * (held - ewma) / 2^16)
  logic signed [ANGLE_BITS:0]   ewma_diff;
  logic signed [EPROD_W-1:0]    ewma_adj, ewma_sum;
  assign ewma_diff = signed'({1'b0, held_r}) - signed'({1'b0, ewma_r});
  assign ewma_adj  = (eprod_r + EPROD_W'(1 << (ALPHA_BITS - 1))) >>> ALPHA_BITS;
  assign ewma_sum  = ewma_adj + signed'(EPROD_W'(ewma_r));

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r   <= CFG_BITS'(655);
      gain_r    <= CFG_BITS'(1536);
      offset_r  <= CFG_BITS'(22016);
      lower_r   <= CFG_BITS'(21248);
      upper_r   <= CFG_BITS'(24832);
      timeout_r <= CFG_BITS'(3000);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ALPHA:   alpha_r   <= cfg_wdata;
        CFG_GAIN:    gain_r    <= cfg_wdata;
        CFG_OFFSET:  offset_r  <= cfg_wdata;
        CFG_LOWER:   lower_r   <= cfg_wdata;
        CFG_UPPER:   upper_r   <= cfg_wdata;
        CFG_TIMEOUT: timeout_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_level_r    <= 1'b0;
      rise_stamp_r    <= '0;
      period_r        <= '0;
      high_r          <= '0;
      pending_r       <= 1'b0;
      last_pulse_ms_r <= '0;
      held_r          <= '0;
      ewma_r          <= EWMA_RESET;
    end else begin
      if (cmd.pin_sample && in_data.pin_level != prev_level_r) begin
        prev_level_r <= in_data.pin_level;
        if (in_data.pin_level) begin
          period_r     <= in_data.tick_count - rise_stamp_r;
          rise_stamp_r <= in_data.tick_count;
        end else begin
          high_r    <= in_data.tick_count - rise_stamp_r;
          pending_r <= 1'b1;
        end
      end
      if (cmd.start_poll && pending_r) begin
        pending_r       <= 1'b0;
        last_pulse_ms_r <= in_data.now_ms;
      end
      if (cmd.ang) held_r <= ang_val;
      if (cmd.qual && qual_status != STATUS_OK) held_r <= upper_q;
      if (cmd.eadd) ewma_r <= ewma_sum[ANGLE_BITS-1:0];
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.start_poll) begin
      now_r   <= in_data.now_ms;
      fresh_r <= pending_r;
      zero_r  <= pending_r && (period_r == '0);
    end
    if (cmd.mul) prod_r <= PROD_W'(gain_q) * PROD_W'(high_r);
    if (cmd.dchk) begin
      sat_r <= over;
      rem_r <= TIME_BITS'(prod_top);
      dvd_r <= prod_r[QUO_W-1:0];
      quo_r <= '0;
    end
    if (cmd.div_step) begin
      rem_r <= div_rem;
      dvd_r <= dvd_r << 1;
      quo_r <= {quo_r[QUO_W-2:0], div_ge};
    end
    if (cmd.qual) status_r <= qual_status;
    if (cmd.emul) eprod_r <= EPROD_W'(signed'({1'b0, alpha_r})) * EPROD_W'(ewma_diff);
    if (cmd.load_out) begin
      out_data_r.smoothed_angle <= ewma_r;
      out_data_r.current_angle  <= held_r;
      out_data_r.status         <= status_r;
      out_data_r.fresh_pulse    <= fresh_r;
    end
  end

  // A passing check leaves the held angle inside the limits
  a_ok_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.qual |=> (status_r != STATUS_OK) || (held_r >= lower_q && held_r <= upper_q))
    else $error("status ok with angle outside limits");

  // Consuming a pulse stamps its poll time
  a_fresh_stamp: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.start_poll && pending_r) |=> (last_pulse_ms_r == $past(in_data.now_ms) && !pending_r))
    else $error("pulse consumption did not update time stamp");

endmodule

// File: sv/pwm_tilt_sensor_conditioner.sv
// ----------------------------------------------------------------------------
// pwm_tilt_sensor_conditioner
// PWM duty-cycle tilt sensor: captures pulse period and high time, converts
// to an angle in Q8.16 degrees on poll, qualifies it and smooths it (EWMA).
//
//   channel  dir  handshake             payload
//   in_      in   in_valid / in_ready   in_item_t (op, pin_level, tick, now)
//   out_     out  out_valid / out_ready out_item_t (angles, status, fresh)
//   cfg_     in   cfg_we                cfg_index, cfg_wdata (16 bit)
//
// Pin samples complete in the cycle they are accepted; they give no result.
// A poll consuming a fresh pulse steps through multiply, the 25-step
// restoring divider, angle, qualify and the EWMA update, and holds the input
// side until its result is loaded; a poll without a new pulse, or whose
// pulse period is zero, goes straight to qualify and the EWMA update.
// One transaction is in work at a time; in_ready is high only while idle.
// A result waits in the output register; a finished poll stalls there until
// the register frees, while the input side is accepted again right after.
// Reset is synchronous, active low, and needs no clearing pass.
// ----------------------------------------------------------------------------
module pwm_tilt_sensor_conditioner import ptsc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]  cfg_wdata
);

  ptsc_cmd_t cmd;
  ptsc_sts_t sts;

  // Sequencer
  ptsc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_data.op),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Arithmetic and state
  ptsc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule
